// ===== rtl/mcg_pkg.sv =====
`default_nettype none
package mcg_pkg;
  localparam int PhaseBits = 24;
  localparam int SineDepth = 1024;
  localparam int MaxBeats = 16;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP = 2'd2;

  localparam logic [2:0] REG_SPB = 3'd0;
  localparam logic [2:0] REG_BPM = 3'd1;
  localparam logic [2:0] REG_LEN = 3'd2;
  localparam logic [2:0] REG_HIGH = 3'd3;
  localparam logic [2:0] REG_LOW = 3'd4;
  localparam logic [2:0] REG_LEVEL = 3'd5;
  localparam logic [2:0] REG_MIX = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROM, ST_S1, ST_S2, ST_S3, ST_S4, ST_DIV, ST_E2, ST_M1, ST_M2, ST_MIX, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/mcg_div.sv =====
`default_nettype none
module mcg_div
  import mcg_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire mcg_pkg::div_ctl_t ctl_in,
  input wire logic [14:0] remaining,
  input wire logic [14:0] length,
  output logic busy,
  output logic [15:0] quot
);
  // restoring divide, one quotient bit per cycle
  logic [30:0] rem_acc;
  logic [30:0] dvd;
  logic [4:0] cnt;
  logic [31:0] trial;
  logic [30:0] q;
  assign trial = {rem_acc, dvd[30]} - {17'd0, length};
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl_in.start) begin
      cnt <= 5'd31;
      rem_acc <= '0;
      dvd <= {remaining, 16'd0} >> 1;
      q <= '0;
    end else if (cnt != 0) begin
      cnt <= cnt - 5'd1;
      dvd <= {dvd[29:0], 1'b0};
      if (!trial[31]) begin
        rem_acc <= trial[30:0];
        q <= {q[29:0], 1'b1};
      end else begin
        rem_acc <= {rem_acc[29:0], dvd[30]};
        q <= {q[29:0], 1'b0};
      end
    end
  end
  assign busy = cnt != 0 || ctl_in.busy;
  assign quot = (length == 0 || q > 31'd32768) ? 16'h8000 : q[15:0];
endmodule
`default_nettype wire

// ===== rtl/metronome_click_generator_core.sv =====
`default_nettype none
// metronome click generator
// input channel: req_type, sample_in with in_valid/in_stall; a sample request
// gives one transaction on the output channel, start and stop give none.
// output channel: sample_out and beat fields with out_valid/out_stall.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, written
// only while idle.
// an audio item goes from acceptance to out_valid through the 31-step
// serial envelope divide, with the sine polynomial running beside it,
// followed by three registered multiplies, the mix stage and the output.
// one item at a time, so a new audio item is taken only after the last has
// gone to the output register; the result sits there so the next item is
// accepted and worked on while it waits, but that item holds in its last stage
// until the result is taken. a stall holds the result steady.
// reset stops the transport, returns the registers to their defaults and
// clears the phase.
module metronome_click_generator_core
  import mcg_pkg::*;
#(
  parameter int PHASE_BITS = mcg_pkg::PhaseBits,
  parameter int SINE_TABLE_DEPTH = mcg_pkg::SineDepth,
  parameter int MAX_BEATS = mcg_pkg::MaxBeats
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic [1:0] req_type,
  input wire logic signed [15:0] sample_in,
  output logic out_valid,
  input wire logic out_stall,
  output logic signed [15:0] sample_out,
  output logic beat_start,
  output logic [4:0] beat_index,
  output logic is_downbeat,
  output logic [19:0] beat_position,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [2:0] cfg_index,
  input wire logic [22:0] cfg_data
);
  localparam int IdxBits = $clog2(SINE_TABLE_DEPTH);

  logic [19:0] spb;
  logic [4:0] bpm;
  logic [14:0] clen;
  logic [22:0] hstep, lstep;
  logic [15:0] level;
  logic mix;

  logic running, use_high;
  logic [19:0] scount;
  logic [4:0] bnum;
  logic [14:0] crem;
  logic [PHASE_BITS-1:0] phase;

  state_t state, state_next;
  logic signed [15:0] x;
  logic has_click;
  logic [14:0] rem_used;
  logic signed [16:0] s;
  logic [15:0] e;
  logic [31:0] prod;
  logic signed [16:0] click;
  logic bs;
  logic [4:0] bidx;
  logic [19:0] bpos;
  logic [15:0] lvl;
  logic [4:0] bpm_c;
  logic div_busy;
  logic [15:0] quot;
  div_ctl_t dctl;
  logic signed [33:0] acc;
  logic signed [18:0] shifted;
  logic [PHASE_BITS-1:0] step;
  logic [PHASE_BITS-1:0] phase_n;
  logic out_free;

  // sine polynomial stages
  logic [11:0] sidx;
  logic [15:0] st;
  logic [1:0] sq;
  logic [14:0] sf, sx2, sp;
  logic [31:0] sraw;
  logic [14:0] smag;

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = state != ST_IDLE;
  assign cfg_ready = state == ST_IDLE;
  assign out_free = !out_valid || !out_stall;
  assign lvl = level > 16'd32768 ? 16'd32768 : level;
  assign bpm_c = bpm > 5'(MAX_BEATS) ? 5'(MAX_BEATS) : bpm;
  assign step = PHASE_BITS'(use_high ? hstep : lstep);
  assign phase_n = phase + step;
  assign dctl = '{start: state == ST_ROM, busy: state == ST_ROM};

  assign sidx = 12'(phase_n >> (PHASE_BITS - IdxBits));
  assign st = 16'({20'd0, sidx} << (16 - IdxBits));
  assign sraw = ((32'd51472 - 32'(sp)) * 32'(sf)) >> 14;
  assign smag = sraw > 32'd32767 ? 15'h7fff : sraw[14:0];

  mcg_div u_div (
    .clk(clk), .rst(rst), .ctl_in(dctl), .remaining(rem_used), .length(clen),
    .busy(div_busy), .quot(quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && req_type == REQ_SAMPLE) state_next = ST_ROM;
      ST_ROM: state_next = ST_S1;
      ST_S1: state_next = ST_S2;
      ST_S2: state_next = ST_S3;
      ST_S3: state_next = ST_S4;
      ST_S4: state_next = ST_DIV;
      ST_DIV: if (!div_busy) state_next = ST_E2;
      ST_E2: state_next = ST_M1;
      ST_M1: state_next = ST_M2;
      ST_M2: state_next = ST_MIX;
      ST_MIX: state_next = ST_OUT;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spb <= 20'd24000;
      bpm <= 5'd4;
      clen <= 15'd480;
      hstep <= 23'd349525;
      lstep <= 23'd279620;
      level <= 16'd16384;
      mix <= 1'b0;
      running <= 1'b0;
      scount <= '0;
      bnum <= 5'd1;
      crem <= '0;
      phase <= '0;
      use_high <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SPB: spb <= cfg_data[19:0];
          REG_BPM: bpm <= cfg_data[4:0];
          REG_LEN: clen <= cfg_data[14:0];
          REG_HIGH: hstep <= cfg_data;
          REG_LOW: lstep <= cfg_data;
          REG_LEVEL: level <= cfg_data[15:0];
          REG_MIX: mix <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        x <= sample_in;
        bidx <= bnum;
        bpos <= scount;
        bs <= 1'b0;
        has_click <= 1'b0;
        case (req_type)
          REQ_START: begin
            running <= 1'b1;
            scount <= '0;
            bnum <= 5'd1;
          end
          REQ_STOP: running <= 1'b0;
          REQ_SAMPLE: if (running) begin
            if (scount == 0) begin
              bs <= 1'b1;
              use_high <= bnum == 5'd1;
              rem_used <= clen;
              crem <= clen == 0 ? 15'd0 : clen - 15'd1;
              has_click <= clen != 0;
            end else begin
              rem_used <= crem;
              crem <= crem == 0 ? 15'd0 : crem - 15'd1;
              has_click <= crem != 0;
            end
            if (scount + 20'd1 >= spb) begin
              scount <= '0;
              bnum <= (bnum + 5'd1 > bpm_c) ? 5'd1 : bnum + 5'd1;
            end else begin
              scount <= scount + 20'd1;
            end
          end
          default: ;
        endcase
      end
      if (state == ST_ROM && has_click) begin
        phase <= phase_n;
      end
      case (state)
        ST_ROM: begin
          sq <= st[15:14];
          sf <= st[14] ? 15'd16384 - {1'b0, st[13:0]} : {1'b0, st[13:0]};
        end
        ST_S1: sx2 <= 15'((32'(sf) * 32'(sf)) >> 14);
        ST_S2: sp <= 15'((32'd2320 * 32'(sx2)) >> 14);
        ST_S3: sp <= 15'(((32'd21024 - 32'(sp)) * 32'(sx2)) >> 14);
        ST_S4: s <= sq[1] ? -$signed({2'b00, smag}) : $signed({2'b00, smag});
        ST_DIV: e <= quot;
        ST_E2: prod <= 32'(e) * 32'(e);
        ST_M1: prod <= 32'(s < 0 ? -s : s) * 32'(prod[30:15]);
        ST_M2: prod <= 32'(prod[30:15]) * 32'(lvl);
        ST_MIX: begin
          click <= has_click ? (s < 0 ? -$signed({1'b0, prod[30:15]})
                                      : $signed({1'b0, prod[30:15]})) : 17'sd0;
        end
        ST_OUT: if (out_free) begin
          beat_start <= bs;
          beat_index <= bidx;
          is_downbeat <= bidx == 5'd1;
          beat_position <= bpos;
          if (!running) begin
            sample_out <= mix ? x : 16'sd0;
          end else if (mix) begin
            sample_out <= shifted > 19'sd32767 ? 16'sh7fff :
                          shifted < -19'sd32768 ? 16'sh8000 : shifted[15:0];
          end else begin
            sample_out <= click > 17'sd32767 ? 16'sh7fff : click[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign acc = 34'(x) * 34'sd26214 + 34'(click) * 34'sd6554;
  assign shifted = 19'(acc >>> 15);

  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid);
  assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |=> out_valid) else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    bnum != 5'd0) else $error("beat number zero");
endmodule
`default_nettype wire

// ===== tb/sv/metronome_click_generator_core_tb.sv =====
`default_nettype none
module metronome_click_generator_core_tb;
  import mcg_pkg::*;

  typedef struct {
    logic signed [15:0] sample_out;
    logic beat_start;
    logic [4:0] beat_index;
    logic is_downbeat;
    logic [19:0] beat_position;
  } click_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = REQ_SAMPLE;
  logic signed [15:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] sample_out;
  logic beat_start;
  logic [4:0] beat_index;
  logic is_downbeat;
  logic [19:0] beat_position;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_SPB;
  logic [22:0] cfg_data = '0;

  metronome_click_generator_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
    .beat_start(beat_start), .beat_index(beat_index), .is_downbeat(is_downbeat),
    .beat_position(beat_position),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // metronome settings
  logic [19:0] m_spb;
  logic [4:0] m_bpm;
  logic [14:0] m_len;
  logic [22:0] m_high, m_low;
  logic [15:0] m_level;
  logic m_mix;
  // metronome state
  logic m_running;
  logic [19:0] m_count;
  logic [4:0] m_beat;
  logic [14:0] m_remaining;
  logic [23:0] m_phase;
  logic m_high_pitch;

  click_result_t pending_clicks[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  function automatic longint sine_of_phase(logic [23:0] ph);
    longint unsigned t, f, x2, p, s;
    logic [1:0] quad;
    t = longint'(ph[23:14]) << 6;
    quad = t[15:14];
    f = t & 16383;
    if (quad[0]) f = 16384 - f;
    x2 = (f * f) >> 14;
    p = (2320 * x2) >> 14;
    p = ((21024 - p) * x2) >> 14;
    s = ((51472 - p) * f) >> 14;
    if (s > 32767) s = 32767;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint next_click_value();
    longint s, mag;
    longint unsigned e, e2, lvl;
    m_phase = m_phase + (m_high_pitch ? m_high : m_low);
    s = sine_of_phase(m_phase);
    if (m_len == 0) e = 32768;
    else begin
      e = (longint'(m_remaining) << 15) / m_len;
      if (e > 32768) e = 32768;
    end
    e2 = (e * e) >> 15;
    lvl = (m_level > 32768) ? 32768 : m_level;
    mag = (s < 0) ? -s : s;
    mag = (((mag * e2) >> 15) * lvl) >> 15;
    return (s < 0) ? -mag : mag;
  endfunction

  function automatic void reset_metronome();
    m_spb = 24000; m_bpm = 4; m_len = 480;
    m_high = 349525; m_low = 279620; m_level = 16384; m_mix = 1'b0;
    m_running = 1'b0; m_count = 0; m_beat = 1; m_remaining = 0;
    m_phase = 0; m_high_pitch = 1'b1;
  endfunction

  function automatic void apply_setting(logic [2:0] idx, logic [22:0] val);
    case (idx)
      REG_SPB: m_spb = val[19:0];
      REG_BPM: m_bpm = val[4:0];
      REG_LEN: m_len = val[14:0];
      REG_HIGH: m_high = val;
      REG_LOW: m_low = val;
      REG_LEVEL: m_level = val[15:0];
      REG_MIX: m_mix = val[0];
      default: ;
    endcase
  endfunction

  function automatic void predict_click(logic [1:0] req, logic signed [15:0] x);
    click_result_t r;
    longint click, acc, y;
    int bpm;
    r.beat_start = 1'b0;
    r.beat_index = m_beat;
    r.is_downbeat = (m_beat == 1);
    r.beat_position = m_count;
    if (req == REQ_START) begin
      m_running = 1'b1; m_count = 0; m_beat = 1;
      return;
    end
    if (req == REQ_STOP) begin
      m_running = 1'b0;
      return;
    end
    if (req != REQ_SAMPLE) return;
    if (!m_running) y = m_mix ? longint'(x) : 0;
    else begin
      click = 0;
      bpm = (m_bpm > MaxBeats) ? MaxBeats : m_bpm;
      if (m_count == 0) begin
        r.beat_start = 1'b1;
        m_remaining = m_len;
        m_high_pitch = (m_beat == 1);
      end
      if (m_remaining > 0) begin
        click = next_click_value();
        m_remaining--;
      end
      if (m_mix) begin
        acc = longint'(x) * 26214 + click * 6554;
        y = acc >>> 15;
      end else y = click;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      m_count++;
      if (m_count >= m_spb) begin
        m_count = 0;
        m_beat++;
        if (m_beat > bpm) m_beat = 1;
      end
    end
    r.sample_out = y[15:0];
    pending_clicks.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    click_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_clicks.size() == 0) begin
        $error("unexpected output transaction");
        fail_count++;
      end else begin
        e = pending_clicks.pop_front();
        if (sample_out !== e.sample_out) begin
          $error("sample_out expected %0d actual %0d", e.sample_out, sample_out);
          fail_count++;
        end
        if (beat_start !== e.beat_start) begin
          $error("beat_start expected %0d actual %0d", e.beat_start, beat_start);
          fail_count++;
        end
        if (beat_index !== e.beat_index) begin
          $error("beat_index expected %0d actual %0d", e.beat_index, beat_index);
          fail_count++;
        end
        if (is_downbeat !== e.is_downbeat) begin
          $error("is_downbeat expected %0d actual %0d", e.is_downbeat, is_downbeat);
          fail_count++;
        end
        if (beat_position !== e.beat_position) begin
          $error("beat_position expected %0d actual %0d", e.beat_position, beat_position);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(logic [1:0] req, logic signed [15:0] x);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    sample_in <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_click(req, x);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [22:0] val);
    in_valid <= 1'b0;
    while (pending_clicks.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_setting(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_clicks.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [15:0] any_sample();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_item(REQ_SAMPLE, 16'sh7fff);
    write_reg(REG_MIX, 23'd1);
    send_item(REQ_SAMPLE, 16'sh8000);
    send_item(2'd3, 16'sh1234);
    wait_idle();
    write_reg(REG_SPB, 23'd3);
    write_reg(REG_BPM, 23'd0);
    write_reg(REG_LEN, 23'd5);
    write_reg(REG_HIGH, 23'h7fffff);
    write_reg(REG_LOW, 23'd0);
    write_reg(REG_LEVEL, 23'hffff);
    send_item(REQ_START, 16'sh0);
    repeat (4) send_item(REQ_SAMPLE, 16'sh7fff);
    repeat (3) send_item(REQ_SAMPLE, 16'sh8000);
    wait_idle();
    // length lowered while a click sounds
    write_reg(REG_LEN, 23'd1);
    write_reg(REG_SPB, 23'd0);
    write_reg(REG_BPM, 23'd31);
    send_item(REQ_SAMPLE, 16'sh0);
    send_item(REQ_SAMPLE, 16'sh1);
    wait_idle();
    write_reg(REG_LEN, 23'd0);
    write_reg(REG_MIX, 23'd0);
    send_item(REQ_SAMPLE, 16'sh7fff);
    send_item(REQ_STOP, 16'sh0);
    send_item(REQ_SAMPLE, 16'sh8000);
    send_item(REQ_START, 16'sh0);
    wait_idle();
  endtask

  task automatic test_random(int kind, int count);
    logic [1:0] req;
    case (kind)
      0: begin
        write_reg(REG_SPB, 23'($urandom_range(1, 12)));
        write_reg(REG_BPM, 23'($urandom_range(1, 5)));
        write_reg(REG_LEN, 23'($urandom_range(1, 10)));
        write_reg(REG_HIGH, 23'($urandom));
        write_reg(REG_LOW, 23'($urandom));
        write_reg(REG_LEVEL, 23'($urandom_range(0, 32768)));
        write_reg(REG_MIX, 23'd1);
      end
      1: begin
        write_reg(REG_SPB, 23'($urandom_range(0, 6)));
        write_reg(REG_BPM, 23'($urandom));
        write_reg(REG_LEN, 23'($urandom));
        write_reg(REG_HIGH, 23'($urandom));
        write_reg(REG_LOW, 23'($urandom));
        write_reg(REG_LEVEL, 23'($urandom));
        write_reg(REG_MIX, 23'd0);
      end
      default: begin
        write_reg(REG_SPB, 23'hfffff);
        write_reg(REG_BPM, 23'd16);
        write_reg(REG_LEN, 23'h7fff);
        write_reg(REG_HIGH, 23'd0);
        write_reg(REG_LOW, 23'h7fffff);
        write_reg(REG_LEVEL, 23'd32768);
        write_reg(REG_MIX, 23'($urandom_range(1)));
      end
    endcase
    send_item(REQ_START, any_sample());
    repeat (count) begin
      case ($urandom_range(39))
        0: req = REQ_START;
        1: req = REQ_STOP;
        2: req = 2'd3;
        default: req = REQ_SAMPLE;
      endcase
      send_item(req, any_sample());
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (12) send_item(REQ_SAMPLE, any_sample());
    wait_idle();
  endtask

  initial begin
    reset_metronome();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 23; recv_stall_pct = 78;
    test_random(0, 90);
    test_random(1, 40);
    send_idle_pct = 78; recv_stall_pct = 23;
    test_random(1, 90);
    test_random(2, 30);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(0, 130);
    test_backpressure();
    if (fail_count == 0) $display("metronome_click_generator_core test passed");
    else $display("metronome_click_generator_core test failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("metronome_click_generator_core test failed");
    $finish;
  end
endmodule
`default_nettype wire
